>>> src/cm_pkg.sv
// Shared constants, types and state codes of the direct-mapped write-back cache.
package cm_pkg;

    localparam int ADDR_BITS  = 18;
    localparam int LINE_COUNT = 128;
    localparam int LINE_BYTES = 128;
    localparam int WORD_BITS  = 32;

    localparam int OFF_BITS   = $clog2(LINE_BYTES);
    localparam int IDX_BITS   = $clog2(LINE_COUNT);
    localparam int WOFF_BITS  = OFF_BITS - 2;
    localparam int TAG_BITS   = ADDR_BITS - OFF_BITS - IDX_BITS;
    localparam int MEM_ABITS  = ADDR_BITS - 2;
    localparam int LW_ABITS   = IDX_BITS + WOFF_BITS;
    localparam int LINE_WORDS = LINE_BYTES / 4;
    localparam int LW_DEPTH   = LINE_COUNT * LINE_WORDS;
    localparam int MEM_DEPTH  = 2 ** MEM_ABITS;

    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] CMD_IDLE  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [ADDR_BITS-1:0] byte_address;
        logic [WORD_BITS-1:0] write_word;
    } t_req;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_word;
        logic                 was_hit;
        logic                 wrote_back;
    } t_rsp;

    typedef struct packed {
        logic                 is_acc;
        logic                 is_wr;
        logic [TAG_BITS-1:0]  tag;
        logic [IDX_BITS-1:0]  idx;
        logic [WOFF_BITS-1:0] woff;
        logic [WORD_BITS-1:0] data;
    } t_job;

    typedef struct packed {
        logic hold;
        logic deq;
    } t_bk_ctl;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_WB_RD,
        S_WB_WR,
        S_RF_RD,
        S_RF_WR,
        S_ACC,
        S_RESP
    } t_state;

endpackage

>>> src/cm_front.sv
// Front end: accepts transactions, decodes them into jobs and queues them for the back end.
module cm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  cm_pkg::t_req   i_req,
    output logic           o_head_valid,
    output cm_pkg::t_job   o_head,
    input  cm_pkg::t_bk_ctl i_ctl
);
    import cm_pkg::*;

    t_job                  r_q [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_cnt;
    t_job                  w_job;
    logic                  w_push, w_pop;

    always_comb begin
        w_job.is_acc = (i_req.cmd == CMD_READ) || (i_req.cmd == CMD_WRITE);
        w_job.is_wr  = (i_req.cmd == CMD_WRITE);
        w_job.tag    = i_req.byte_address[ADDR_BITS-1 -: TAG_BITS];
        w_job.idx    = i_req.byte_address[OFF_BITS +: IDX_BITS];
        w_job.woff   = i_req.byte_address[2 +: WOFF_BITS];
        w_job.data   = i_req.write_word;
    end

    assign o_full       = (r_cnt == Q_CNT_BITS'(Q_DEPTH)) || i_ctl.hold;
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rd_ptr];
    assign w_push       = i_push && !o_full;
    assign w_pop        = i_ctl.deq && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> src/cm_back.sv
// Back end: tag lookup, write-back, refill and word access sequencer with all storage.
module cm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  cm_pkg::t_job    i_head,
    output cm_pkg::t_bk_ctl o_ctl,
    output logic            o_empty,
    input  logic            i_pop,
    output cm_pkg::t_rsp    o_rsp
);
    import cm_pkg::*;

    logic [TAG_BITS-1:0]  r_tag_mem [LINE_COUNT];
    logic [WORD_BITS-1:0] r_lw_mem  [LW_DEPTH];
    logic [WORD_BITS-1:0] r_bm_mem  [MEM_DEPTH];

    t_state               r_state, n_state;
    t_job                 r_job;
    logic [WOFF_BITS-1:0] r_cnt;
    logic [MEM_ABITS-1:0] r_clr;
    logic [TAG_BITS-1:0]  r_tag_q;
    logic [WORD_BITS-1:0] r_lw_q, r_bm_q;
    logic                 r_hit, r_wb;
    logic                 r_valid [LINE_COUNT];
    logic                 r_dirty [LINE_COUNT];
    logic                 r_out_valid;
    t_rsp                 r_out;

    logic                 w_hit, w_victim_dirty, w_slot_free, w_last;
    logic                 w_deq, w_tag_we, w_lw_we, w_lw_re, w_bm_we, w_bm_re, w_load;
    logic [LW_ABITS-1:0]  w_lw_waddr, w_lw_raddr;
    logic [WORD_BITS-1:0] w_lw_wdata, w_bm_wdata;
    logic [MEM_ABITS-1:0] w_bm_waddr, w_bm_raddr;

    assign w_hit          = r_valid[r_job.idx] && (r_tag_q == r_job.tag);
    assign w_victim_dirty = r_valid[r_job.idx] && r_dirty[r_job.idx];
    assign w_slot_free    = !r_out_valid || i_pop;
    assign w_last         = (r_cnt == WOFF_BITS'(LINE_WORDS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == MEM_ABITS'(MEM_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_head_valid) begin
                    n_state = i_head.is_acc ? S_LOOK : S_RESP;
                end
            end
            S_LOOK: begin
                priority if (w_hit) begin
                    n_state = S_ACC;
                end else if (w_victim_dirty) begin
                    n_state = S_WB_RD;
                end else begin
                    n_state = S_RF_RD;
                end
            end
            S_WB_RD: n_state = S_WB_WR;
            S_WB_WR: n_state = w_last ? S_RF_RD : S_WB_RD;
            S_RF_RD: n_state = S_RF_WR;
            S_RF_WR: n_state = w_last ? S_ACC : S_RF_RD;
            S_ACC:   n_state = S_RESP;
            S_RESP:  if (w_slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_deq      = 1'b0;
        w_tag_we   = 1'b0;
        w_lw_we    = 1'b0;
        w_lw_re    = 1'b0;
        w_bm_we    = 1'b0;
        w_bm_re    = 1'b0;
        w_load     = 1'b0;
        w_lw_waddr = {r_job.idx, r_cnt};
        w_lw_raddr = {r_job.idx, r_cnt};
        w_lw_wdata = r_bm_q;
        w_bm_waddr = {r_tag_q, r_job.idx, r_cnt};
        w_bm_raddr = {r_job.tag, r_job.idx, r_cnt};
        w_bm_wdata = r_lw_q;
        unique case (r_state)
            S_CLEAR: begin
                w_bm_we    = 1'b1;
                w_bm_waddr = r_clr;
                w_bm_wdata = '0;
            end
            S_IDLE:  w_deq = i_head_valid;
            S_WB_RD: w_lw_re = 1'b1;
            S_WB_WR: w_bm_we = 1'b1;
            S_RF_RD: w_bm_re = 1'b1;
            S_RF_WR: begin
                w_lw_we  = 1'b1;
                w_tag_we = w_last;
            end
            S_ACC: begin
                w_lw_raddr = {r_job.idx, r_job.woff};
                w_lw_waddr = {r_job.idx, r_job.woff};
                w_lw_wdata = r_job.data;
                w_lw_we    = r_job.is_wr;
                w_lw_re    = !r_job.is_wr;
            end
            S_RESP:  w_load = w_slot_free;
            default: ;
        endcase
    end

    assign o_ctl.hold = (r_state == S_CLEAR);
    assign o_ctl.deq  = w_deq;
    assign o_empty    = !r_out_valid;
    assign o_rsp      = r_out;

    // Storage arrays.
    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            r_tag_mem[r_job.idx] <= r_job.tag;
        end
        if (w_deq) begin
            r_tag_q <= r_tag_mem[i_head.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lw_we) begin
            r_lw_mem[w_lw_waddr] <= w_lw_wdata;
        end
        if (w_lw_re) begin
            r_lw_q <= r_lw_mem[w_lw_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_bm_we) begin
            r_bm_mem[w_bm_waddr] <= w_bm_wdata;
        end
        if (w_bm_re) begin
            r_bm_q <= r_bm_mem[w_bm_raddr];
        end
    end

    // Job and result payload.
    always_ff @(posedge i_clk) begin
        if (w_deq) begin
            r_job <= i_head;
        end
        if (r_state == S_LOOK) begin
            r_hit <= w_hit;
            r_wb  <= !w_hit && w_victim_dirty;
        end
        if (w_load) begin
            r_out.read_word  <= (r_job.is_acc && !r_job.is_wr) ? r_lw_q : '0;
            r_out.was_hit    <= r_job.is_acc && r_hit;
            r_out.wrote_back <= r_job.is_acc && r_wb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LINE_COUNT; i++) begin
                r_valid[i] <= 1'b0;
                r_dirty[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_LOOK) begin
                r_cnt <= '0;
            end else if (r_state == S_WB_WR || r_state == S_RF_WR) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_tag_we) begin
                r_valid[r_job.idx] <= 1'b1;
                r_dirty[r_job.idx] <= 1'b0;
            end
            if (r_state == S_ACC && r_job.is_wr) begin
                r_dirty[r_job.idx] <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A write-back only ever happens on a miss.
    a_wb_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.was_hit && r_out.wrote_back))
        else $error("result reports both hit and write-back");

    // No job leaves the queue while the backing memory is being cleared.
    a_no_deq_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !w_deq)
        else $error("job taken during clearing pass");

    // A hit goes straight to the word access.
    a_hit_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && w_hit) |=> (r_state == S_ACC))
        else $error("hit did not proceed to access");

    // A refill ends with the line valid and the tag stored.
    a_refill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tag_we |=> r_valid[$past(r_job.idx)])
        else $error("refilled line not valid");

endmodule

>>> src/direct_mapped_writeback_cache.sv
// Top level of the direct-mapped write-back write-allocate cache with its backing memory.
// After reset the backing memory is cleared one word per cycle (65536 words for an
// 18-bit address), and full stays high until that pass ends. Transactions then enter a
// two-entry queue and are served one at a time by a single-ported sequencer: an idle
// command passes through dequeue and result, a hit through dequeue, tag lookup, word
// access and result; a miss adds a refill of the 32-word line, preceded by a write-back
// of the dirty victim line when there is one. Each word moves through one memory read
// and one memory write. A finished result waits in an output register while the next
// transactions are accepted into the queue.
module direct_mapped_writeback_cache (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         push,
    output logic         full,
    input  cm_pkg::t_req i_req,
    output logic         empty,
    input  logic         pop,
    output cm_pkg::t_rsp o_rsp
);
    import cm_pkg::*;

    logic    w_head_valid;
    t_job    w_head;
    t_bk_ctl w_ctl;

    cm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_req        (i_req),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_ctl        (w_ctl)
    );

    cm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_ctl        (w_ctl),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_rsp        (o_rsp)
    );

endmodule
